FILE: rtl/iil_pkg.sv
// ============================================================================
// iil_pkg: shared types and constants of the indexed insert/remove list
// sizes of the store, request and response layouts, memory port bundle
// ============================================================================
package iil_pkg;

   localparam int CAPACITY  = 256;
   localparam int WORD_BITS = 32;
   localparam int ADDR_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS  = ADDR_BITS + 1;

   // request modes
   localparam logic [2:0] MODE_READ   = 3'd0;
   localparam logic [2:0] MODE_WRITE  = 3'd1;
   localparam logic [2:0] MODE_INSERT = 3'd2;
   localparam logic [2:0] MODE_APPEND = 3'd3;
   localparam logic [2:0] MODE_REMOVE = 3'd4;
   localparam logic [2:0] MODE_SETCNT = 3'd5;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  index;
      logic        at_tail;
      logic [31:0] data;
      logic [8:0]  new_count;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic [8:0]  count;
      logic [1:0]  status;
   } rsp_type;

   // one write and one read port of the entry store
   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      logic [WORD_BITS-1:0] wdata;
      logic                 re;
      logic [ADDR_BITS-1:0] raddr;
   } mem_req_type;

   // finished request handed to the response register
   typedef struct packed {
      logic                 fire;
      logic [WORD_BITS-1:0] value;
      logic [CNT_BITS-1:0]  count;
      logic [1:0]           status;
   } done_type;

endpackage

FILE: rtl/iil_mem.sv
// ============================================================================
// iil_mem: entry store
// one write port, one read port with registered read data
// ============================================================================
module iil_mem
   import iil_pkg::*;
(
   input  logic                 clock,
   input  mem_req_type          mem_req,
   output logic [WORD_BITS-1:0] rdata
);

   logic [WORD_BITS-1:0] entries_ff [CAPACITY];
   logic [WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         entries_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= entries_ff[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/iil_ctrl.sv
// ============================================================================
// iil_ctrl: request sequencer
// decodes a request, then walks one address pointer through the store
// ============================================================================
module iil_ctrl
   import iil_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  req_type              req_item,
   input  logic                 out_free,
   input  logic [WORD_BITS-1:0] rdata,
   output logic                 idle,
   output mem_req_type          mem_req,
   output done_type             done
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD   = 7'b0000010,
      S_SHUP = 7'b0000100,
      S_SHDN = 7'b0001000,
      S_FILL = 7'b0010000,
      S_PUT  = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   logic [WORD_BITS-1:0] data_ff, data_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  ncnt_ff, ncnt_in;
   logic [1:0]           status_ff, status_in;
   logic [WORD_BITS-1:0] value_ff, value_in;
   logic [CNT_BITS-1:0]  addr_ff, addr_in;
   logic [CNT_BITS-1:0]  wr_ff, wr_in;
   logic [CNT_BITS-1:0]  last_ff, last_in;

   // shared pointer unit: one step and one end compare
   logic                 step_up;
   logic [CNT_BITS-1:0]  addr_step;
   logic                 at_last;

   // decode helpers
   logic [CNT_BITS-1:0]  idx9;
   logic [CNT_BITS-1:0]  ins_pos;
   logic [CNT_BITS-1:0]  ins_max;
   logic [CNT_BITS:0]    ins_ncnt;
   logic [CNT_BITS-1:0]  rem_pos;
   logic [CNT_BITS-1:0]  rem_next;

   assign step_up   = (state_ff == S_SHDN) || (state_ff == S_FILL);
   assign addr_step = step_up ? addr_ff + CNT_BITS'(1) : addr_ff - CNT_BITS'(1);
   assign at_last   = (addr_ff == last_ff);

   assign idx9     = {1'b0, req_item.index};
   assign ins_pos  = req_item.at_tail ? cnt_ff : idx9;
   assign ins_max  = (ins_pos > cnt_ff) ? ins_pos : cnt_ff;
   assign ins_ncnt = {1'b0, ins_max} + (CNT_BITS+1)'(1);
   assign rem_pos  = req_item.at_tail ? cnt_ff - CNT_BITS'(1) : idx9;
   assign rem_next = rem_pos + CNT_BITS'(1);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      data_in   = data_ff;
      cnt_in    = cnt_ff;
      ncnt_in   = ncnt_ff;
      status_in = status_ff;
      value_in  = value_ff;
      addr_in   = addr_ff;
      wr_in     = wr_ff;
      last_in   = last_ff;
      mem_req   = '0;
      done      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_item.mode;
               data_in   = req_item.data[WORD_BITS-1:0];
               status_in = ST_OK;
               value_in  = '0;
               ncnt_in   = cnt_ff;
               state_in  = S_FIN;
               case (req_item.mode)
                  MODE_READ, MODE_WRITE: begin
                     if (idx9 < cnt_ff) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = req_item.index[ADDR_BITS-1:0];
                        pos_in        = idx9;
                        state_in      = S_RD;
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  MODE_INSERT: begin
                     if (ins_ncnt > (CNT_BITS+1)'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        ncnt_in = ins_ncnt[CNT_BITS-1:0];
                        pos_in  = ins_pos;
                        if (ins_pos < cnt_ff) begin
                           mem_req.re    = 1'b1;
                           mem_req.raddr = ADDR_BITS'(cnt_ff - CNT_BITS'(1));
                           addr_in       = cnt_ff - CNT_BITS'(1);
                           wr_in         = cnt_ff;
                           last_in       = ins_pos;
                           state_in      = S_SHUP;
                        end else if (ins_pos > cnt_ff) begin
                           addr_in  = cnt_ff;
                           last_in  = ins_pos - CNT_BITS'(1);
                           state_in = S_FILL;
                        end else begin
                           state_in = S_PUT;
                        end
                     end
                  end
                  MODE_APPEND: begin
                     if (cnt_ff >= CNT_BITS'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in   = cnt_ff;
                        ncnt_in  = cnt_ff + CNT_BITS'(1);
                        state_in = S_PUT;
                     end
                  end
                  MODE_REMOVE: begin
                     if ((cnt_ff == '0) || (rem_pos >= cnt_ff)) begin
                        status_in = ST_RANGE;
                     end else begin
                        ncnt_in = cnt_ff - CNT_BITS'(1);
                        if (rem_next < cnt_ff) begin
                           mem_req.re    = 1'b1;
                           mem_req.raddr = rem_next[ADDR_BITS-1:0];
                           addr_in       = rem_next;
                           wr_in         = rem_pos;
                           last_in       = cnt_ff - CNT_BITS'(1);
                           state_in      = S_SHDN;
                        end
                     end
                  end
                  MODE_SETCNT: begin
                     if (req_item.new_count > CNT_BITS'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        ncnt_in = req_item.new_count;
                        if (req_item.new_count > cnt_ff) begin
                           addr_in  = cnt_ff;
                           last_in  = req_item.new_count - CNT_BITS'(1);
                           state_in = S_FILL;
                        end
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_RD: begin
            value_in = rdata;
            if (op_ff == MODE_WRITE) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pos_ff[ADDR_BITS-1:0];
               mem_req.wdata = data_ff;
            end
            state_in = S_FIN;
         end
         S_SHUP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wr_ff[ADDR_BITS-1:0];
            mem_req.wdata = rdata;
            wr_in         = addr_ff;
            if (at_last) begin
               state_in = S_PUT;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = addr_step[ADDR_BITS-1:0];
               addr_in       = addr_step;
            end
         end
         S_SHDN: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wr_ff[ADDR_BITS-1:0];
            mem_req.wdata = rdata;
            wr_in         = addr_ff;
            if (at_last) begin
               state_in = S_FIN;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = addr_step[ADDR_BITS-1:0];
               addr_in       = addr_step;
            end
         end
         S_FILL: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = addr_ff[ADDR_BITS-1:0];
            mem_req.wdata = '0;
            if (at_last) begin
               state_in = (op_ff == MODE_INSERT) ? S_PUT : S_FIN;
            end else begin
               addr_in = addr_step;
            end
         end
         S_PUT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff[ADDR_BITS-1:0];
            mem_req.wdata = data_ff;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               done.fire = 1'b1;
               cnt_in    = ncnt_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      done.value  = value_ff;
      done.count  = ncnt_ff;
      done.status = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      data_ff   <= data_in;
      ncnt_ff   <= ncnt_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      addr_ff   <= addr_in;
      wr_ff     <= wr_in;
      last_ff   <= last_in;
   end

   assign idle = (state_ff == S_IDLE);

endmodule

FILE: rtl/indexed_insert_remove_list.sv
// ============================================================================
// indexed_insert_remove_list: ordered word list with indexed insert/remove
// a 256-entry store of 32-bit words plus a live count, one request at a time
// ============================================================================
// A request is taken while the sequencer is idle and then occupies it until
// its response is queued. Requests that shift or zero-fill entries walk a
// single address pointer through a one-write, one-read memory, moving or
// clearing one entry per cycle, so the time per request follows the number
// of entries touched. A response register sits between the sequencer and
// the response channel, so a new request may be taken while the previous
// response is still stalled. There is no clearing pass after reset: only
// entries below the live count are ever read, and those have been written.
// ============================================================================
module indexed_insert_remove_list
   import iil_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic                 idle;
   logic                 req_fire;
   logic                 out_free;
   mem_req_type          mem_req;
   logic [WORD_BITS-1:0] rdata;
   done_type             done;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_item_ff, rsp_item_in;

   // requests are only taken while the sequencer is idle
   assign req_stall = reset | ~idle;
   assign req_fire  = req_valid & ~req_stall;

   // the response slot is free when empty or when its transfer completes now
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   iil_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_item (req_item),
      .out_free (out_free),
      .rdata    (rdata),
      .idle     (idle),
      .mem_req  (mem_req),
      .done     (done)
   );

   iil_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (done.fire) begin
         // load a finished request into the response slot
         rsp_valid_in       = 1'b1;
         rsp_item_in.value  = 32'(done.value);
         rsp_item_in.count  = done.count;
         rsp_item_in.status = done.status;
      end else if (~rsp_stall) begin
         // transfer completed, slot empties
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: rtl/iil_checker.sv
// ============================================================================
// iil_checker: port-level checks of the indexed insert/remove list
// watches both channels and is bound to the top level
// ============================================================================
module iil_checker
   import iil_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   // a stalled response holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
   else $error("response changed while stalled");

   // one request at a time: a transfer in closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
   else $error("request taken while busy");

   // refused requests carry no word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != ST_OK) |-> rsp_item.value == '0)
   else $error("refused request returned a word");

   // the live count never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.count <= 9'(CAPACITY))
   else $error("count beyond capacity");

   // no response straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
   else $error("response valid after reset");

endmodule

bind indexed_insert_remove_list iil_checker u_iil_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the indexed insert/remove list
// drives read, write, insert, append, remove and set-count requests through
// the valid/stall channels under several idling patterns, predicts every
// response with a behavioural copy of the list and compares it field by field
// ============================================================================
module tb;
   import iil_pkg::*;

   // modes six and seven have no meaning and must be ignored by the block
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;

   localparam int ITEMS_PER_PHASE = 313;   // four phases, about 1250 requests
   localparam int HANG_LIMIT      = 5000;  // quiet cycles before giving up
   localparam int TAIL_CYCLES     = 300;   // idle run after every owed response has come back

   // -------------------------------------------------------------------------
   // scoreboard: behavioural list plus the queue of responses still owed
   // -------------------------------------------------------------------------
   class list_scoreboard;
      logic [WORD_BITS-1:0] store [CAPACITY];
      int unsigned          length     = 0;
      int unsigned          peak       = 0;
      rsp_type              owed_q [$];
      int unsigned          errors     = 0;
      int unsigned          checked    = 0;
      int unsigned          mode_seen [8];

      // work out the response of one accepted request and update the list
      function void note_request(input req_type r);
         rsp_type     res;
         int unsigned pos;
         int unsigned grown;
         int          i;
         res        = '0;
         res.status = ST_OK;
         mode_seen[r.mode]++;
         case (r.mode)
            MODE_READ: begin
               if (r.index < length) res.value = store[r.index];
               else res.status = ST_RANGE;
            end
            MODE_WRITE: begin
               if (r.index < length) begin
                  res.value      = store[r.index];
                  store[r.index] = r.data;
               end else begin
                  res.status = ST_RANGE;
               end
            end
            MODE_INSERT: begin
               pos   = r.at_tail ? length : r.index;
               grown = 1 + ((pos > length) ? pos : length);
               if (grown > CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  if (pos < length) begin
                     for (i = length; i > pos; i--) store[i] = store[i-1];
                  end else begin
                     for (i = length; i < pos; i++) store[i] = '0;
                  end
                  store[pos] = r.data;
                  length     = grown;
               end
            end
            MODE_APPEND: begin
               if (length >= CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  store[length] = r.data;
                  length++;
               end
            end
            MODE_REMOVE: begin
               pos = r.at_tail ? length - 1 : r.index;
               if (length == 0 || pos >= length) begin
                  res.status = ST_RANGE;
               end else begin
                  for (i = pos; i + 1 < length; i++) store[i] = store[i+1];
                  length--;
               end
            end
            MODE_SETCNT: begin
               if (r.new_count > CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  for (i = length; i < r.new_count; i++) store[i] = '0;
                  length = 32'(r.new_count);
               end
            end
            default: ;
         endcase
         res.count = 9'(length);
         if (length > peak) peak = length;
         owed_q.push_back(res);
      endfunction

      // compare one accepted response with the oldest one owed
      function void check_result(input rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            $error("response with nothing outstanding: value %h count %0d status %0d",
                   got.value, got.count, got.status);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         checked++;
         if (got.value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, got.value);
            errors++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block under test
   // -------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   list_scoreboard sb = new;

   int unsigned send_gap_pct  = 0;   // chance per slot that the sender idles
   int unsigned rsp_stall_pct = 0;   // chance per cycle that the receiver stalls
   int unsigned quiet_cycles  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   indexed_insert_remove_list i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // -------------------------------------------------------------------------
   // response side: random back-pressure and checking of every transfer
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_item);
   end

   // watchdog: a long run of cycles with no transfer on either side means a hang
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == HANG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   function automatic req_type make_req(input logic [2:0] mode, input logic [7:0] index,
                                        input logic at_tail, input logic [31:0] data,
                                        input logic [8:0] new_count);
      req_type r;
      r.mode      = mode;
      r.index     = index;
      r.at_tail   = at_tail;
      r.data      = data;
      r.new_count = new_count;
      return r;
   endfunction

   // offer one request, idling first at random; valid is only lowered in idle
   // slots so back-to-back transfers never see a low/high pair in one step
   task automatic send_item(input req_type r);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer happened at this edge
      sb.note_request(r);
   endtask

   // hold off new requests until every owed response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_q.size() != 0) @(posedge clock);
   endtask

   // mostly in-range positions so that shifts and replacements dominate,
   // with the odd wild index, oversized count and unused mode as noise
   function automatic req_type random_request(input int unsigned length);
      req_type     r;
      int unsigned pick;
      pick      = $urandom_range(0, 99);
      r.data    = $urandom();
      r.at_tail = ($urandom_range(0, 3) == 0);
      if (length > 0 && $urandom_range(0, 9) < 8) r.index = 8'($urandom_range(0, length - 1));
      else r.index = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 19))
         0, 1:    r.new_count = 9'($urandom_range(257, 511));
         2:       r.new_count = 9'(CAPACITY);
         3, 4, 5: r.new_count = 9'($urandom_range(0, 8));
         default: r.new_count = 9'($urandom_range(0, 256));
      endcase
      if (pick < 15)      r.mode = MODE_READ;
      else if (pick < 30) r.mode = MODE_WRITE;
      else if (pick < 50) r.mode = MODE_INSERT;
      else if (pick < 62) r.mode = MODE_APPEND;
      else if (pick < 90) r.mode = MODE_REMOVE;
      else if (pick < 97) r.mode = MODE_SETCNT;
      else r.mode = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned served;
      int unsigned phase;
      req_type     r;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, growth, gap fill, full list and the unused modes
      send_item(make_req(MODE_READ,   8'd0,   1'b0, 32'h0,        9'd0));
      send_item(make_req(MODE_REMOVE, 8'd0,   1'b1, 32'h0,        9'd0));
      send_item(make_req(MODE_APPEND, 8'd0,   1'b0, 32'hFFFFFFFF, 9'd0));
      send_item(make_req(MODE_APPEND, 8'd0,   1'b0, 32'h00000000, 9'd0));
      send_item(make_req(MODE_INSERT, 8'd0,   1'b0, 32'hA5A5A5A5, 9'd0));
      send_item(make_req(MODE_INSERT, 8'd255, 1'b1, 32'h5A5A5A5A, 9'd0));
      send_item(make_req(MODE_INSERT, 8'd10,  1'b0, 32'h12345678, 9'd0));
      send_item(make_req(MODE_READ,   8'd5,   1'b0, 32'h0,        9'd0));
      send_item(make_req(MODE_WRITE,  8'd0,   1'b0, 32'h00000000, 9'd0));
      send_item(make_req(MODE_WRITE,  8'd11,  1'b0, 32'hDEADBEEF, 9'd0));
      send_item(make_req(MODE_READ,   8'd255, 1'b0, 32'h0,        9'd0));
      send_item(make_req(MODE_REMOVE, 8'd2,   1'b0, 32'h0,        9'd0));
      send_item(make_req(MODE_REMOVE, 8'd0,   1'b1, 32'h0,        9'd0));
      send_item(make_req(MODE_SPARE6, 8'd255, 1'b1, 32'hFFFFFFFF, 9'd511));
      send_item(make_req(MODE_SPARE7, 8'd3,   1'b0, 32'h0F0F0F0F, 9'd0));
      send_item(make_req(MODE_SETCNT, 8'd0,   1'b0, 32'h0,        9'd511));
      send_item(make_req(MODE_SETCNT, 8'd0,   1'b0, 32'h0,        9'd256));
      send_item(make_req(MODE_APPEND, 8'd0,   1'b0, 32'hCAFEF00D, 9'd0));
      send_item(make_req(MODE_INSERT, 8'd0,   1'b1, 32'h1, 9'd0));
      send_item(make_req(MODE_INSERT, 8'd255, 1'b0, 32'h2, 9'd0));
      send_item(make_req(MODE_WRITE,  8'd255, 1'b0, 32'hFFFFFFFF, 9'd0));
      send_item(make_req(MODE_REMOVE, 8'd0,   1'b0, 32'h0,        9'd0));
      send_item(make_req(MODE_SETCNT, 8'd0,   1'b0, 32'h0,        9'd0));
      send_item(make_req(MODE_INSERT, 8'd255, 1'b0, 32'h87654321, 9'd0));
      send_item(make_req(MODE_SETCNT, 8'd0,   1'b0, 32'h0,        9'd3));

      // random phases: no idling, sender gaps, receiver stalls, then both;
      // each phase starts from a fully drained block
      for (phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0:       begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_gap_pct = 57; rsp_stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  rsp_stall_pct = 57; end
            default: begin send_gap_pct = 27; rsp_stall_pct = 27; end
         endcase
         served = 0;
         while (served < ITEMS_PER_PHASE) begin
            r = random_request(sb.length);
            send_item(r);
            // ignored modes do not count towards the phase
            if (r.mode <= MODE_SETCNT) served++;
         end
      end

      req_valid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered read %0d, write %0d, insert %0d, append %0d, remove %0d, set-count %0d,",
               sb.mode_seen[MODE_READ], sb.mode_seen[MODE_WRITE], sb.mode_seen[MODE_INSERT],
               sb.mode_seen[MODE_APPEND], sb.mode_seen[MODE_REMOVE], sb.mode_seen[MODE_SETCNT]);
      $display("unused modes %0d; %0d responses checked, list grew to %0d entries",
               sb.mode_seen[MODE_SPARE6] + sb.mode_seen[MODE_SPARE7], sb.checked, sb.peak);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: indexed_insert_remove_list.f
rtl/iil_pkg.sv
rtl/iil_mem.sv
rtl/iil_ctrl.sv
rtl/indexed_insert_remove_list.sv
rtl/iil_checker.sv
tb/tb.sv
